@@ hdl/tll_pkg.sv @@
// Shared types and constants for the text token lexer.
package tll_pkg;

  localparam int LINE_BITS_DEF     = 20;
  localparam int COLUMN_BITS_DEF   = 16;
  localparam int MANTISSA_BITS_DEF = 64;
  localparam int EXPONENT_BITS_DEF = 16;

  // Result queue depth; one item can push two results.
  localparam int RQ_DEPTH = 4;

  typedef enum logic [3:0] {
    TK_END      = 4'd0,
    TK_COMMA    = 4'd1,
    TK_LBRACE   = 4'd2,
    TK_RBRACE   = 4'd3,
    TK_LBRACKET = 4'd4,
    TK_RBRACKET = 4'd5,
    TK_INTEGER  = 4'd6,
    TK_REAL     = 4'd7,
    TK_TEXT_CHR = 4'd8,
    TK_TEXT_END = 4'd9,
    TK_ERROR    = 4'd10
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_COMMENT    = 3'd2,
    ERR_NUMBER     = 3'd3,
    ERR_STRING     = 3'd4
  } error_code_e;

  typedef struct packed {
    logic       end_of_input;
    logic [7:0] char_value;
  } in_item_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [7:0]         text_char;
    logic signed [63:0] mantissa;
    logic signed [15:0] decimal_exponent;
    logic [19:0]        start_line;
    logic [15:0]        start_column;
    error_code_e        error_code;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

endpackage

@@ hdl/text_token_lexer_unit.sv @@
// Path from input accept to the first output result: input register, then result queue.
// Throughput: one character item per cycle while the queue can take two results; results
//   drain one per cycle, so two-result items (a token closed by punctuation) slow intake.
// The lexer state update sits between the input register and the result queue.
// Reset (rst_ni, async low): start state, line 1 column 0, queue empty, not halted.
// An error result halts the lexer; later items are taken and dropped until reset.
module text_token_lexer_unit import tll_pkg::*; #(
  parameter int LINE_BITS     = LINE_BITS_DEF,
  parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     in_valid_q;
  in_item_t in_q;
  logic     room;
  logic     go;
  logic     accept;
  logic     halted;
  push_t    push;

  // the held item moves on only when the queue can absorb two results
  assign go         = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_item_i;
  end

  tll_core #(
    .LINE_BITS    (LINE_BITS),
    .COLUMN_BITS  (COLUMN_BITS),
    .MANTISSA_BITS(MANTISSA_BITS),
    .EXPONENT_BITS(EXPONENT_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .item_i  (in_q),
    .push_o  (push),
    .halted_o(halted)
  );

  tll_res_q #(
    .DEPTH(RQ_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_valid_o && !out_stall_i),
    .room_o (room),
    .valid_o(out_valid_o),
    .item_o (out_item_o)
  );

`ifndef SYNTHESIS
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |-> push.count == 2'd0) else $error("result pushed while halted");
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q) else $error("stall without a held item");
  a_last_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 2'd2 |-> push.res1.last && !push.res0.last)
    else $error("bad last marking on two results");
  a_last_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 2'd1 |-> push.res0.last) else $error("single result not last");
`endif

endmodule

@@ hdl/tll_core.sv @@
// Lexer FSM: consumes one character item per cycle on go_i, emits up to two results.
module tll_core import tll_pkg::*; #(
  parameter int LINE_BITS     = LINE_BITS_DEF,
  parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  in_item_t item_i,
  output push_t    push_o,
  output logic     halted_o
);

  localparam logic [3:0] ST_START   = 4'd0;
  localparam logic [3:0] ST_SLASH   = 4'd1;
  localparam logic [3:0] ST_COMMENT = 4'd2;
  localparam logic [3:0] ST_SIGN    = 4'd3;
  localparam logic [3:0] ST_INT     = 4'd4;
  localparam logic [3:0] ST_DOT     = 4'd5;
  localparam logic [3:0] ST_FRAC    = 4'd6;
  localparam logic [3:0] ST_EXP     = 4'd7;
  localparam logic [3:0] ST_ESIGN   = 4'd8;
  localparam logic [3:0] ST_EDIG    = 4'd9;
  localparam logic [3:0] ST_STR     = 4'd10;
  localparam logic [3:0] ST_ESC     = 4'd11;
  localparam logic [3:0] ST_IDENT   = 4'd12;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  localparam int MW = MANTISSA_BITS + 4;
  localparam int EW = EXPONENT_BITS + 4;
  localparam int RW = EXPONENT_BITS + 2;
  localparam int CW = COLUMN_BITS + 1;

  localparam logic [MANTISSA_BITS-1:0] MANT_MAX = {1'b0, {(MANTISSA_BITS-1){1'b1}}};
  localparam logic [EXPONENT_BITS-1:0] EXP_MAX  = {1'b0, {(EXPONENT_BITS-1){1'b1}}};
  localparam logic [LINE_BITS-1:0]     LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0]   COL_MAX  = {COLUMN_BITS{1'b1}};
  localparam logic [MANTISSA_BITS-1:0] INT_POS  = MANTISSA_BITS'(32'h7FFF_FFFF);
  localparam logic [MANTISSA_BITS-1:0] INT_NEG  = MANTISSA_BITS'(32'h8000_0000);

  logic [3:0]               st_q, st_d;
  logic [MANTISSA_BITS-1:0] macc_q, macc_d;
  logic [EXPONENT_BITS-1:0] eacc_q, eacc_d;
  logic [EXPONENT_BITS-1:0] frac_q, frac_d;
  logic                     mneg_q, mneg_d;
  logic                     eneg_q, eneg_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [COLUMN_BITS-1:0]   col_q, col_d;
  logic [LINE_BITS-1:0]     tsl_q, tsl_d;
  logic [COLUMN_BITS-1:0]   tsc_q, tsc_d;
  logic                     ovs_q, ovs_d;
  logic                     halt_q, halt_d;

  out_item_t res [2];
  logic [1:0] n;

  // 10*a + d with saturation; MSB of the result flags overflow
  function automatic logic [MANTISSA_BITS:0] mant_step(logic [MANTISSA_BITS-1:0] a,
                                                        logic [3:0] d);
    logic [MW-1:0] t;
    t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + MW'(d);
    if (t > MW'(MANT_MAX)) mant_step = {1'b1, MANT_MAX};
    else mant_step = {1'b0, t[MANTISSA_BITS-1:0]};
  endfunction

  function automatic logic [EXPONENT_BITS:0] exp_step(logic [EXPONENT_BITS-1:0] a,
                                                       logic [3:0] d);
    logic [EW-1:0] t;
    t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + EW'(d);
    if (t > EW'(EXP_MAX)) exp_step = {1'b1, EXP_MAX};
    else exp_step = {1'b0, t[EXPONENT_BITS-1:0]};
  endfunction

  function automatic out_item_t mk(token_kind_e k, logic [7:0] ch, logic [63:0] m,
                                   logic [15:0] e, logic [LINE_BITS-1:0] l,
                                   logic [COLUMN_BITS-1:0] cl, error_code_e er, logic o);
    out_item_t r;
    r.token_kind       = k;
    r.text_char        = ch;
    r.mantissa         = m;
    r.decimal_exponent = e;
    r.start_line       = 20'(l);
    r.start_column     = 16'(cl);
    r.error_code       = er;
    r.overflow         = o;
    r.last             = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic                     eoi;
    logic [7:0]               c;
    logic                     dig, alpha, is_e, do_start, adv;
    logic [3:0]               dv;
    logic [MANTISSA_BITS:0]   ms;
    logic [EXPONENT_BITS:0]   es;
    logic [MANTISSA_BITS-1:0] im, lim;
    logic                     iov, rov;
    logic signed [RW-1:0]     ev, emax_s;
    logic [CW-1:0]            tab;
    logic [63:0]              m64;

    eoi   = item_i.end_of_input;
    c     = item_i.char_value;
    dig   = (c >= 8'h30) && (c <= 8'h39);
    alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
            (c == CH_USCORE);
    is_e  = (c == CH_UE) || (c == CH_LE);
    dv    = c[3:0];

    st_d = st_q; macc_d = macc_q; eacc_d = eacc_q; frac_d = frac_q;
    mneg_d = mneg_q; eneg_d = eneg_q; line_d = line_q; col_d = col_q;
    tsl_d = tsl_q; tsc_d = tsc_q; ovs_d = ovs_q; halt_d = halt_q;
    res[0] = '0;
    res[1] = '0;
    n = 2'd0;
    do_start = 1'b0;
    adv = 1'b0;
    ms = '0; es = '0; im = '0; lim = '0; iov = 1'b0; rov = 1'b0;
    ev = '0; m64 = '0;
    emax_s = $signed({2'b00, EXP_MAX});

    // number finishers, used only on the arms that emit them
    lim = mneg_q ? INT_NEG : INT_POS;
    im  = macc_q;
    iov = ovs_q;
    if (macc_q > lim) begin
      im  = lim;
      iov = 1'b1;
    end
    ev  = $signed({2'b00, eacc_q});
    if (eneg_q) ev = -ev;
    ev  = ev - $signed({2'b00, frac_q});
    rov = ovs_q;
    if (ev > emax_s) begin
      ev  = emax_s;
      rov = 1'b1;
    end else if (ev < ~emax_s) begin
      ev  = ~emax_s;
      rov = 1'b1;
    end

    unique case (st_q)
      ST_SLASH: begin
        if (eoi || c != CH_SLASH) begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_COMMENT, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end else begin
          st_d = ST_COMMENT; adv = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (eoi) begin
          do_start = 1'b1;
        end else begin
          if (c == CH_LF) st_d = ST_START;
          adv = 1'b1;
        end
      end
      ST_SIGN: begin
        if (!eoi && dig) begin
          macc_d = MANTISSA_BITS'(dv); st_d = ST_INT; adv = 1'b1;
        end else if (!eoi && c == CH_DOT) begin
          st_d = ST_DOT; adv = 1'b1;
        end else begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_NUMBER, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end
      end
      ST_INT: begin
        if (!eoi && dig) begin
          ms = mant_step(macc_q, dv);
          macc_d = ms[MANTISSA_BITS-1:0];
          ovs_d = ovs_q | ms[MANTISSA_BITS];
          adv = 1'b1;
        end else if (!eoi && c == CH_DOT) begin
          st_d = ST_FRAC; adv = 1'b1;
        end else if (!eoi && is_e) begin
          st_d = ST_EXP; adv = 1'b1;
        end else begin
          m64 = 64'(im);
          if (mneg_q) m64 = 64'd0 - m64;
          res[n[0]] = mk(TK_INTEGER, '0, m64, '0, tsl_d, tsc_d, ERR_NONE, iov);
          n = n + 2'd1; do_start = 1'b1;
        end
      end
      ST_DOT: begin
        if (!eoi && dig) begin
          macc_d = MANTISSA_BITS'(dv);
          frac_d = EXPONENT_BITS'(1);
          st_d = ST_FRAC; adv = 1'b1;
        end else begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_NUMBER, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end
      end
      ST_FRAC, ST_EDIG: begin
        if (!eoi && dig && st_q == ST_FRAC) begin
          ms = mant_step(macc_q, dv);
          macc_d = ms[MANTISSA_BITS-1:0];
          ovs_d = ovs_q | ms[MANTISSA_BITS] | (frac_q >= EXP_MAX);
          if (frac_q < EXP_MAX) frac_d = frac_q + EXPONENT_BITS'(1);
          adv = 1'b1;
        end else if (!eoi && dig) begin
          es = exp_step(eacc_q, dv);
          eacc_d = es[EXPONENT_BITS-1:0];
          ovs_d = ovs_q | es[EXPONENT_BITS];
          adv = 1'b1;
        end else if (!eoi && is_e && st_q == ST_FRAC) begin
          st_d = ST_EXP; adv = 1'b1;
        end else begin
          m64 = 64'(macc_q);
          if (mneg_q) m64 = 64'd0 - m64;
          res[n[0]] = mk(TK_REAL, '0, m64, 16'(ev), tsl_d, tsc_d, ERR_NONE, rov);
          n = n + 2'd1; do_start = 1'b1;
        end
      end
      ST_EXP, ST_ESIGN: begin
        if (!eoi && st_q == ST_EXP && (c == CH_PLUS || c == CH_MINUS)) begin
          eneg_d = (c == CH_MINUS); st_d = ST_ESIGN; adv = 1'b1;
        end else if (!eoi && dig) begin
          eacc_d = EXPONENT_BITS'(dv); st_d = ST_EDIG; adv = 1'b1;
        end else begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_NUMBER, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end
      end
      ST_STR: begin
        if (eoi || c == CH_LF) begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_STRING, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end else if (c == CH_BSL) begin
          st_d = ST_ESC; adv = 1'b1;
        end else if (c == CH_QUOTE) begin
          res[n[0]] = mk(TK_TEXT_END, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
          n = n + 2'd1; st_d = ST_START; adv = 1'b1;
        end else begin
          res[n[0]] = mk(TK_TEXT_CHR, c, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
          n = n + 2'd1; adv = 1'b1;
        end
      end
      ST_ESC: begin
        if (eoi) begin
          res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_STRING, 1'b0);
          n = n + 2'd1; halt_d = 1'b1; st_d = ST_START;
        end else begin
          res[n[0]] = mk(TK_TEXT_CHR, c, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
          n = n + 2'd1; st_d = ST_STR; adv = 1'b1;
        end
      end
      ST_IDENT: begin
        if (!eoi && (dig || alpha)) begin
          res[n[0]] = mk(TK_TEXT_CHR, c, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
          n = n + 2'd1; adv = 1'b1;
        end else begin
          res[n[0]] = mk(TK_TEXT_END, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
          n = n + 2'd1; do_start = 1'b1;
        end
      end
      default: do_start = 1'b1;
    endcase

    // start-state pass; also the re-scan of a terminating character
    if (do_start) begin
      st_d = ST_START;
      tsl_d = line_q; tsc_d = col_q;
      macc_d = '0; eacc_d = '0; frac_d = '0;
      mneg_d = 1'b0; eneg_d = 1'b0; ovs_d = 1'b0;
      adv = 1'b1;
      if (eoi) begin
        res[n[0]] = mk(TK_END, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1; adv = 1'b0;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        st_d = ST_START;
      end else if (c == CH_SLASH) begin
        st_d = ST_SLASH;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        mneg_d = (c == CH_MINUS); st_d = ST_SIGN;
      end else if (dig) begin
        macc_d = MANTISSA_BITS'(dv); st_d = ST_INT;
      end else if (c == CH_DOT) begin
        st_d = ST_DOT;
      end else if (c == CH_QUOTE) begin
        st_d = ST_STR;
      end else if (alpha) begin
        res[n[0]] = mk(TK_TEXT_CHR, c, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1; st_d = ST_IDENT;
      end else if (c == CH_COMMA) begin
        res[n[0]] = mk(TK_COMMA, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1;
      end else if (c == CH_LBRC) begin
        res[n[0]] = mk(TK_LBRACE, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1;
      end else if (c == CH_RBRC) begin
        res[n[0]] = mk(TK_RBRACE, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1;
      end else if (c == CH_LBRK) begin
        res[n[0]] = mk(TK_LBRACKET, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1;
      end else if (c == CH_RBRK) begin
        res[n[0]] = mk(TK_RBRACKET, '0, '0, '0, tsl_d, tsc_d, ERR_NONE, 1'b0);
        n = n + 2'd1;
      end else begin
        res[n[0]] = mk(TK_ERROR, '0, '0, '0, tsl_d, tsc_d, ERR_UNEXPECTED, 1'b0);
        n = n + 2'd1; halt_d = 1'b1; adv = 1'b0;
      end
    end

    // position tracking
    tab = {1'b0, col_q[COLUMN_BITS-1:3], 3'b000} + CW'(8);
    if (adv) begin
      if (c == CH_LF) begin
        if (line_q < LINE_MAX) line_d = line_q + LINE_BITS'(1);
        col_d = '0;
      end else if (c == CH_TAB) begin
        col_d = (tab > CW'(COL_MAX)) ? COL_MAX : tab[COLUMN_BITS-1:0];
      end else if (col_q < COL_MAX) begin
        col_d = col_q + COLUMN_BITS'(1);
      end
    end

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_START; macc_q <= '0; eacc_q <= '0; frac_q <= '0;
      mneg_q <= 1'b0; eneg_q <= 1'b0;
      line_q <= LINE_BITS'(1); col_q <= '0;
      tsl_q <= LINE_BITS'(1); tsc_q <= '0;
      ovs_q <= 1'b0; halt_q <= 1'b0;
    end else if (go_i && !halt_q) begin
      st_q <= st_d; macc_q <= macc_d; eacc_q <= eacc_d; frac_q <= frac_d;
      mneg_q <= mneg_d; eneg_q <= eneg_d;
      line_q <= line_d; col_q <= col_d;
      tsl_q <= tsl_d; tsc_q <= tsc_d;
      ovs_q <= ovs_d; halt_q <= halt_d;
    end
  end

  assign push_o.count = (go_i && !halt_q) ? n : 2'd0;
  assign push_o.res0  = res[0];
  assign push_o.res1  = res[1];
  assign halted_o     = halt_q;

endmodule

@@ hdl/tll_res_q.sv @@
// Small result queue: takes up to two results per cycle, hands out one.
module tll_res_q import tll_pkg::*; #(
  parameter int DEPTH = RQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output out_item_t item_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t        mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_q + PW'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(push_i.count);
      rd_q  <= rd_q + PW'(pop_i);
      cnt_q <= cnt_q + CW'(push_i.count) - CW'(pop_i);
    end
  end

  assign room_o  = cnt_q <= CW'(DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

endmodule
